// File: hdl/rars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_pkg
// Shared sizes, codes, types and overlap helpers for the offline rectangle
// add / rectangle sum block.
// ----------------------------------------------------------------------------
package rars_pkg;

  // store sizes and coordinate width
  localparam int MAX_ADDS    = 64;
  localparam int MAX_QUERIES = 64;
  localparam int COORD_BITS  = 20;

  // fixed field widths of the stream words
  localparam int FIELD_W  = 20;
  localparam int WEIGHT_W = 32;
  localparam int QI_W     = 6;
  localparam int TOTAL_W  = 64;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 72;

  // address and count widths
  localparam int AA_W  = (MAX_ADDS > 1) ? $clog2(MAX_ADDS) : 1;
  localparam int QA_W  = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
  localparam int ACNT_W = $clog2(MAX_ADDS + 1);
  localparam int QCNT_W = $clog2(MAX_QUERIES + 1);

  // store word widths
  localparam int BND_W   = 2 * COORD_BITS;
  localparam int QWORD_W = 2 * BND_W;
  localparam int AWORD_W = 2 * BND_W + WEIGHT_W;

  // arithmetic widths: overlap, weight*overlap, split point
  localparam int OV_W    = COORD_BITS + 2;
  localparam int P_W     = WEIGHT_W + OV_W;
  localparam int SPLIT   = P_W / 2;
  localparam int PLO_W   = SPLIT + 1 + OV_W;
  localparam int PHI_W   = (P_W - SPLIT) + OV_W;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_EMIT  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } seq_state_t;

  // one recorded rectangle from the input word
  typedef struct packed {
    logic                  add_we;
    logic                  query_we;
    logic [BND_W-1:0]      xb;
    logic [BND_W-1:0]      yb;
    logic [WEIGHT_W-1:0]   w;
  } rec_t;

  // store read controls from the sequencer
  typedef struct packed {
    logic            q_re;
    logic [QA_W-1:0] q_addr;
    logic            a_re;
    logic [AA_W-1:0] a_addr;
  } rd_ctl_t;

  // datapath controls from the sequencer
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  // h(a,b) = max(0, a-b)
  function automatic logic [COORD_BITS-1:0] pos_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    pos_diff = (a > b) ? (a - b) : '0;
  endfunction

  // overlap along one axis of a query and an add, bounds packed lo | hi<<CB
  function automatic logic signed [OV_W-1:0] axis_overlap(
    input logic [BND_W-1:0] qb,
    input logic [BND_W-1:0] ab
  );
    logic [COORD_BITS-1:0] qlo, qhi, alo, ahi;
    logic signed [OV_W-1:0] t0, t1, t2, t3;
    qlo = qb[COORD_BITS-1:0];
    qhi = qb[BND_W-1:COORD_BITS];
    alo = ab[COORD_BITS-1:0];
    ahi = ab[BND_W-1:COORD_BITS];
    t0 = $signed({2'b00, pos_diff(qhi, alo)});
    t1 = $signed({2'b00, pos_diff(qhi, ahi)});
    t2 = $signed({2'b00, pos_diff(qlo, alo)});
    t3 = $signed({2'b00, pos_diff(qlo, ahi)});
    axis_overlap = t0 - t1 - t2 + t3;
  endfunction

endpackage

// File: hdl/rars_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_store
// Add and query rectangle memories with fill counts and the sticky drop flag.
// ----------------------------------------------------------------------------
module rars_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rars_pkg::rec_t             rec,
  input  rars_pkg::rd_ctl_t          rd_ctl,
  output logic [rars_pkg::AWORD_W-1:0] a_rdata,
  output logic [rars_pkg::QWORD_W-1:0] q_rdata,
  output logic [rars_pkg::ACNT_W-1:0]  add_cnt,
  output logic [rars_pkg::QCNT_W-1:0]  query_cnt,
  output logic                       dropped
);
  import rars_pkg::*;

  logic [AWORD_W-1:0] add_mem [MAX_ADDS];
  logic [QWORD_W-1:0] query_mem [MAX_QUERIES];

  logic [ACNT_W-1:0]  add_cnt_r, add_cnt_nxt;
  logic [QCNT_W-1:0]  query_cnt_r, query_cnt_nxt;
  logic               drop_r, drop_nxt;
  logic [AWORD_W-1:0] a_rdata_r;
  logic [QWORD_W-1:0] q_rdata_r;
  logic               add_room, query_room;

  assign add_room   = add_cnt_r < ACNT_W'(MAX_ADDS);
  assign query_room = query_cnt_r < QCNT_W'(MAX_QUERIES);

  // fill counts and drop flag
  always_comb begin
    add_cnt_nxt   = add_cnt_r;
    query_cnt_nxt = query_cnt_r;
    drop_nxt      = drop_r;
    if (rec.add_we) begin
      if (add_room) add_cnt_nxt = add_cnt_r + 1'b1;
      else          drop_nxt    = 1'b1;
    end
    if (rec.query_we) begin
      if (query_room) query_cnt_nxt = query_cnt_r + 1'b1;
      else            drop_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_cnt_r   <= '0;
      query_cnt_r <= '0;
      drop_r      <= 1'b0;
    end else begin
      add_cnt_r   <= add_cnt_nxt;
      query_cnt_r <= query_cnt_nxt;
      drop_r      <= drop_nxt;
    end
  end

  // add memory: write at fill count, registered read
  always_ff @(posedge clk) begin
    if (rec.add_we && add_room) begin
      add_mem[add_cnt_r[AA_W-1:0]] <= {rec.w, rec.yb, rec.xb};
    end
    if (rd_ctl.a_re) begin
      a_rdata_r <= add_mem[rd_ctl.a_addr];
    end
  end

  // query memory: write at fill count, registered read
  always_ff @(posedge clk) begin
    if (rec.query_we && query_room) begin
      query_mem[query_cnt_r[QA_W-1:0]] <= {rec.yb, rec.xb};
    end
    if (rd_ctl.q_re) begin
      q_rdata_r <= query_mem[rd_ctl.q_addr];
    end
  end

  assign a_rdata   = a_rdata_r;
  assign q_rdata   = q_rdata_r;
  assign add_cnt   = add_cnt_r;
  assign query_cnt = query_cnt_r;
  assign dropped   = drop_r;

endmodule

// File: hdl/rars_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_mac
// Pipelined weight * x overlap * y overlap product and 64-bit accumulator.
// ----------------------------------------------------------------------------
module rars_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rars_pkg::mac_ctl_t           ctl,
  input  logic [rars_pkg::AWORD_W-1:0] a_rdata,
  input  logic [rars_pkg::QWORD_W-1:0] q_rdata,
  output logic [rars_pkg::TOTAL_W-1:0] acc,
  output logic                         busy
);
  import rars_pkg::*;

  // stage valids: read data, overlaps, w*ox, partial products, term
  logic v_rd_r, v_ov_r, v_p_r, v_pp_r, v_t_r;

  logic signed [OV_W-1:0]     ox_r, oy_r, oy2_r;
  logic signed [WEIGHT_W-1:0] w_r;
  logic signed [P_W-1:0]      p_r;
  logic signed [PLO_W-1:0]    plo_r;
  logic signed [PHI_W-1:0]    phi_r;
  logic [TOTAL_W-1:0]         term_r, term_nxt;
  logic [TOTAL_W-1:0]         acc_r;
  logic signed [TOTAL_W-1:0]  phi_ext, plo_ext;

  logic [BND_W-1:0]    a_xb, a_yb, q_xb, q_yb;
  logic [WEIGHT_W-1:0] a_w;

  assign a_xb = a_rdata[BND_W-1:0];
  assign a_yb = a_rdata[2*BND_W-1:BND_W];
  assign a_w  = a_rdata[AWORD_W-1:2*BND_W];
  assign q_xb = q_rdata[BND_W-1:0];
  assign q_yb = q_rdata[2*BND_W-1:BND_W];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r <= 1'b0;
      v_ov_r <= 1'b0;
      v_p_r  <= 1'b0;
      v_pp_r <= 1'b0;
      v_t_r  <= 1'b0;
    end else begin
      v_rd_r <= ctl.issue;
      v_ov_r <= v_rd_r;
      v_p_r  <= v_ov_r;
      v_pp_r <= v_p_r;
      v_t_r  <= v_pp_r;
    end
  end

  // overlaps from the two read words
  always_ff @(posedge clk) begin
    ox_r <= axis_overlap(q_xb, a_xb);
    oy_r <= axis_overlap(q_yb, a_yb);
    w_r  <= $signed(a_w);
  end

  // weight times x overlap
  always_ff @(posedge clk) begin
    p_r   <= w_r * ox_r;
    oy2_r <= oy_r;
  end

  // split product times y overlap
  always_ff @(posedge clk) begin
    plo_r <= $signed({1'b0, p_r[SPLIT-1:0]}) * oy2_r;
    phi_r <= $signed(p_r[P_W-1:SPLIT]) * oy2_r;
  end

  // recombine partial products, wrap to 64 bits
  assign phi_ext  = TOTAL_W'(phi_r);
  assign plo_ext  = TOTAL_W'(plo_r);
  assign term_nxt = (phi_ext << SPLIT) + plo_ext;

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clear) begin
      acc_r <= '0;
    end else if (v_t_r) begin
      acc_r <= acc_r + term_r;
    end
  end

  assign acc  = acc_r;
  assign busy = v_rd_r | v_ov_r | v_p_r | v_pp_r | v_t_r;

endmodule

// File: hdl/rars_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_seq
// Answer sequencer: walks queries, streams adds into the datapath and holds
// the output word register.
// ----------------------------------------------------------------------------
module rars_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         emit,
  input  logic [rars_pkg::ACNT_W-1:0]  add_cnt,
  input  logic [rars_pkg::QCNT_W-1:0]  query_cnt,
  input  logic                         dropped,
  input  logic                         mac_busy,
  input  logic [rars_pkg::TOTAL_W-1:0] acc,
  input  logic                         out_ready,
  output logic                         idle,
  output rars_pkg::rd_ctl_t            rd_ctl,
  output rars_pkg::mac_ctl_t           mac_ctl,
  output logic                         out_valid,
  output logic [rars_pkg::QI_W-1:0]    out_index,
  output logic [rars_pkg::TOTAL_W-1:0] out_total,
  output logic                         out_last,
  output logic                         out_ovf
);
  import rars_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [QCNT_W-1:0]  q_idx_r, q_idx_nxt;
  logic [ACNT_W-1:0]  a_idx_r, a_idx_nxt;
  logic               ov_r, ov_nxt;
  logic [QI_W-1:0]    idx_r;
  logic [TOTAL_W-1:0] total_r;
  logic               last_r, ovf_r;
  logic               load;
  logic               q_last, a_last, slot_free;

  assign q_last    = (q_idx_r + 1'b1) == query_cnt;
  assign a_last    = (a_idx_r + 1'b1) == add_cnt;
  assign slot_free = !ov_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (emit && (query_cnt != '0)) state_nxt = ST_QREAD;
      end
      ST_QREAD: begin
        state_nxt = (add_cnt == '0) ? ST_DRAIN : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (a_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) state_nxt = q_last ? ST_IDLE : ST_QREAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    idle          = 1'b0;
    rd_ctl.q_re   = 1'b0;
    rd_ctl.q_addr = q_idx_r[QA_W-1:0];
    rd_ctl.a_re   = 1'b0;
    rd_ctl.a_addr = a_idx_r[AA_W-1:0];
    mac_ctl.clear = 1'b0;
    mac_ctl.issue = 1'b0;
    load          = 1'b0;
    q_idx_nxt     = q_idx_r;
    a_idx_nxt     = a_idx_r;
    case (state_r)
      ST_IDLE: begin
        idle      = 1'b1;
        q_idx_nxt = '0;
      end
      ST_QREAD: begin
        rd_ctl.q_re   = 1'b1;
        mac_ctl.clear = 1'b1;
        a_idx_nxt     = '0;
      end
      ST_ISSUE: begin
        rd_ctl.a_re   = 1'b1;
        mac_ctl.issue = 1'b1;
        a_idx_nxt     = a_idx_r + 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RESULT: begin
        if (slot_free) begin
          load      = 1'b1;
          q_idx_nxt = q_idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output word valid
  always_comb begin
    ov_nxt = ov_r;
    if (load)           ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      q_idx_r <= '0;
      a_idx_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      q_idx_r <= q_idx_nxt;
      a_idx_r <= a_idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      idx_r   <= QI_W'(q_idx_r[QA_W-1:0]);
      total_r <= acc;
      last_r  <= q_last;
      ovf_r   <= dropped;
    end
  end

  assign out_valid = ov_r;
  assign out_index = idx_r;
  assign out_total = total_r;
  assign out_last  = last_r;
  assign out_ovf   = ovf_r;

endmodule

// File: hdl/rect_add_rect_sum_offline_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_add_rect_sum_offline_core
// Offline rectangle weight adds and rectangle sum queries: records rectangles
// in two memories and answers every query on an emit word.
// ----------------------------------------------------------------------------
// Add, query and unused words: taken one per cycle while the core is idle, no result.
// Emit word: per query, one query read, one add memory read per add, drain of
//   the five-stage multiply pipeline and a result load once the output slot
//   is free; input stalls until the last answer is loaded into the output
//   register.
// Reset: counts and drop flag clear at once; memories need no clearing pass.
// ----------------------------------------------------------------------------
module rect_add_rect_sum_offline_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_low[19:0], x_high[39:20], y_low[59:40], y_high[79:60], weight[111:80]
  input  logic [rars_pkg::IN_DATA_W-1:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // query_index[5:0], total[69:6], zero fill[71:70]
  output logic [rars_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic        out_tlast,
  // overflow[0]
  output logic        out_tuser
);
  import rars_pkg::*;

  rec_t                rec;
  rd_ctl_t             rd_ctl;
  mac_ctl_t            mac_ctl;
  logic [AWORD_W-1:0]  a_rdata;
  logic [QWORD_W-1:0]  q_rdata;
  logic [ACNT_W-1:0]   add_cnt;
  logic [QCNT_W-1:0]   query_cnt;
  logic                dropped, mac_busy, idle, in_acc, emit;
  logic [TOTAL_W-1:0]  acc, out_total;
  logic [QI_W-1:0]     out_index;
  func_t               func;

  assign in_tready = idle;
  assign in_acc    = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);
  assign emit      = in_acc && (func == FUNC_EMIT);

  // unpack the input word, low bits of each bound
  always_comb begin
    rec.add_we   = in_acc && (func == FUNC_ADD);
    rec.query_we = in_acc && (func == FUNC_QUERY);
    rec.xb       = {in_tdata[FIELD_W +: COORD_BITS], in_tdata[COORD_BITS-1:0]};
    rec.yb       = {in_tdata[3*FIELD_W +: COORD_BITS],
                    in_tdata[2*FIELD_W +: COORD_BITS]};
    rec.w        = in_tdata[4*FIELD_W +: WEIGHT_W];
  end

  rars_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (rec),
    .rd_ctl    (rd_ctl),
    .a_rdata   (a_rdata),
    .q_rdata   (q_rdata),
    .add_cnt   (add_cnt),
    .query_cnt (query_cnt),
    .dropped   (dropped)
  );

  rars_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .a_rdata (a_rdata),
    .q_rdata (q_rdata),
    .acc     (acc),
    .busy    (mac_busy)
  );

  rars_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .add_cnt   (add_cnt),
    .query_cnt (query_cnt),
    .dropped   (dropped),
    .mac_busy  (mac_busy),
    .acc       (acc),
    .out_ready (out_tready),
    .idle      (idle),
    .rd_ctl    (rd_ctl),
    .mac_ctl   (mac_ctl),
    .out_valid (out_tvalid),
    .out_index (out_index),
    .out_total (out_total),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

  // pack the output word
  assign out_tdata = {(OUT_DATA_W - QI_W - TOTAL_W)'(0), out_total, out_index};

endmodule
